### design/wavelength_to_rgb_defines.svh
// Assertion macros for the wavelength to RGB block.
`ifndef WAVELENGTH_TO_RGB_DEFINES_SVH
`define WAVELENGTH_TO_RGB_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define W2RGB_ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("wavelength_to_rgb: property failed");

// Consequent that must hold a fixed number of cycles after the antecedent.
`define W2RGB_ASSERT_LATER(label, clk, rst, ante, n, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error("wavelength_to_rgb: delayed property failed");

`endif

### design/w2rgb_pkg.sv
`default_nettype none

package w2rgb_pkg;

   localparam int GAMMA_INDEX_BITS_DEF = 10;
   localparam int WAVE_FRAC_BITS_DEF   = 4;

   localparam int WAVE_W   = 14;
   localparam int COLOUR_W = 8;

   // Q1.16 ramp and factor values
   localparam int Q_FRAC  = 16;
   localparam int RAMP_W  = Q_FRAC + 1;
   localparam int PROD_W  = 2 * RAMP_W;
   localparam logic [RAMP_W-1:0] Q_ONE = RAMP_W'(1 << Q_FRAC);

   // ramp numerator scaled to 16 fraction bits, divided by a constant
   // through a rounded-up reciprocal; exact for every reachable numerator
   localparam int X_W         = 26;
   localparam int RECIP_SHIFT = 36;
   localparam int RECIP_W     = 32;
   localparam int MUL_W       = X_W + RECIP_W;

   localparam logic [RECIP_W-1:0] RECIP_20  =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd19) / 64'd20);
   localparam logic [RECIP_W-1:0] RECIP_50  =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd49) / 64'd50);
   localparam logic [RECIP_W-1:0] RECIP_60  =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd59) / 64'd60);
   localparam logic [RECIP_W-1:0] RECIP_65  =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd64) / 64'd65);
   localparam logic [RECIP_W-1:0] RECIP_70  =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd69) / 64'd70);
   localparam logic [RECIP_W-1:0] RECIP_400 =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd399) / 64'd400);
   localparam logic [RECIP_W-1:0] RECIP_800 =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd799) / 64'd800);

   // request to response, in cycles
   localparam int PIPE_LATENCY = 4;

endpackage

`default_nettype wire

### design/w2rgb_gamma_rom.sv
`default_nettype none

module w2rgb_gamma_rom import w2rgb_pkg::*; #(
   parameter int GAMMA_INDEX_BITS = GAMMA_INDEX_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic [GAMMA_INDEX_BITS-1:0] rd_idx,
   output logic      [COLOUR_W-1:0]         rd_data
);

   localparam int DEPTH = 1 << GAMMA_INDEX_BITS;

   // floor(255 * (idx/M)^0.8): largest v with v^5 * M^4 <= idx^4 * 255^5
   function automatic logic [COLOUR_W-1:0] gamma_entry(input int unsigned idx);
      logic [127:0]        m;
      logic [127:0]        m4;
      logic [127:0]        iw;
      logic [127:0]        i4;
      logic [127:0]        k5;
      logic [127:0]        c;
      logic [127:0]        c5;
      logic [COLOUR_W-1:0] v;
      logic [COLOUR_W-1:0] trial;
      m  = (128'd1 << GAMMA_INDEX_BITS) - 128'd1;
      m4 = m * m * m * m;
      iw = 128'(idx);
      i4 = iw * iw * iw * iw;
      k5 = 128'd255 * 128'd255 * 128'd255 * 128'd255 * 128'd255;
      v  = '0;
      for (int b = COLOUR_W - 1; b >= 0; b--) begin
         trial = v | (COLOUR_W'(1) << b);
         c     = 128'(trial);
         c5    = c * c * c * c * c;
         if (c5 * m4 <= i4 * k5) begin
            v = trial;
         end
      end
      return v;
   endfunction

   logic [COLOUR_W-1:0] rom [DEPTH];
   logic [COLOUR_W-1:0] rd_data_ff;

   for (genvar i = 0; i < DEPTH; i++) begin : g_entry
      localparam logic [COLOUR_W-1:0] ENTRY = gamma_entry(i);
      assign rom[i] = ENTRY;
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= rom[rd_idx];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/wavelength_to_rgb.sv
// Channel    Ports                                    Transfer
// request    start, busy, req_wavelength_q4           start && !busy at clock edge
// response   rsp_valid, rsp_red, rsp_green, rsp_blue  one-cycle strobe, no hold-off
//
// One request per clock; each response passes the stage 1-3 and ROM registers.
// Stages: band decode, reciprocal multiply for the ramps, intensity multiply,
// gamma ROM read. The reciprocal and intensity multipliers set the cycle time.
// busy stays low. Synchronous reset clears the stage valid bits only.
// Nothing stalls: the response side takes every strobe.
`default_nettype none

module wavelength_to_rgb import w2rgb_pkg::*; #(
   parameter int GAMMA_INDEX_BITS = GAMMA_INDEX_BITS_DEF,
   parameter int WAVE_FRAC_BITS   = WAVE_FRAC_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [WAVE_W-1:0]   req_wavelength_q4,
   output logic                     rsp_valid,
   output logic      [COLOUR_W-1:0] rsp_red,
   output logic      [COLOUR_W-1:0] rsp_green,
   output logic      [COLOUR_W-1:0] rsp_blue
);

   localparam int CALC_W  = 18 + WAVE_FRAC_BITS;
   localparam int SCALE   = 1 << WAVE_FRAC_BITS;
   localparam int X_SHIFT = Q_FRAC - WAVE_FRAC_BITS;

   localparam logic [CALC_W-1:0] W380 = CALC_W'(380 * SCALE);
   localparam logic [CALC_W-1:0] W420 = CALC_W'(420 * SCALE);
   localparam logic [CALC_W-1:0] W440 = CALC_W'(440 * SCALE);
   localparam logic [CALC_W-1:0] W490 = CALC_W'(490 * SCALE);
   localparam logic [CALC_W-1:0] W510 = CALC_W'(510 * SCALE);
   localparam logic [CALC_W-1:0] W580 = CALC_W'(580 * SCALE);
   localparam logic [CALC_W-1:0] W645 = CALC_W'(645 * SCALE);
   localparam logic [CALC_W-1:0] W701 = CALC_W'(701 * SCALE);
   localparam logic [CALC_W-1:0] W781 = CALC_W'(781 * SCALE);
   localparam logic [CALC_W-1:0] FAC_OFS_LO = CALC_W'(2540 * SCALE);
   localparam logic [CALC_W-1:0] FAC_OFS_HI = CALC_W'(5700 * SCALE);

   typedef enum logic [2:0] {
      BAND_NONE,
      BAND_VB,
      BAND_BC,
      BAND_CG,
      BAND_GY,
      BAND_YR,
      BAND_RED
   } band_type;

   typedef enum logic [1:0] {
      FAC_ZERO,
      FAC_ONE,
      FAC_RAMP
   } fac_type;

   // saturate to Q0.16 and keep the top index bits
   function automatic logic [GAMMA_INDEX_BITS-1:0] shade_index(input logic [PROD_W-1:0] p);
      logic [Q_FRAC-1:0] lvl;
      lvl = (p[PROD_W-1:2*Q_FRAC] != '0) ? '1 : p[2*Q_FRAC-1:Q_FRAC];
      return lvl[Q_FRAC-1 -: GAMMA_INDEX_BITS];
   endfunction

   // stage 1: band decode and ramp numerators
   logic [CALC_W-1:0]  w_ext;
   logic [CALC_W-1:0]  w_x7;
   logic [CALC_W-1:0]  num_c;
   logic [CALC_W-1:0]  num_f;
   logic               s1_valid_in;
   band_type           s1_band_in;
   fac_type            s1_fac_in;
   logic [X_W-1:0]     s1_xc_in;
   logic [X_W-1:0]     s1_xf_in;
   logic [RECIP_W-1:0] s1_mc_in;
   logic [RECIP_W-1:0] s1_mf_in;
   logic               s1_valid_ff;
   band_type           s1_band_ff;
   fac_type            s1_fac_ff;
   logic [X_W-1:0]     s1_xc_ff;
   logic [X_W-1:0]     s1_xf_ff;
   logic [RECIP_W-1:0] s1_mc_ff;
   logic [RECIP_W-1:0] s1_mf_ff;

   assign busy        = 1'b0;
   assign s1_valid_in = start && !busy;

   always_comb begin
      w_ext      = CALC_W'(req_wavelength_q4);
      w_x7       = (w_ext << 3) - w_ext;
      s1_band_in = BAND_NONE;
      num_c      = '0;
      s1_mc_in   = '0;
      if (w_ext >= W380 && w_ext < W781) begin
         if (w_ext < W440) begin
            s1_band_in = BAND_VB;
            num_c      = W440 - w_ext;
            s1_mc_in   = RECIP_60;
         end else if (w_ext < W490) begin
            s1_band_in = BAND_BC;
            num_c      = w_ext - W440;
            s1_mc_in   = RECIP_50;
         end else if (w_ext < W510) begin
            s1_band_in = BAND_CG;
            num_c      = W510 - w_ext;
            s1_mc_in   = RECIP_20;
         end else if (w_ext < W580) begin
            s1_band_in = BAND_GY;
            num_c      = w_ext - W510;
            s1_mc_in   = RECIP_70;
         end else if (w_ext < W645) begin
            s1_band_in = BAND_YR;
            num_c      = W645 - w_ext;
            s1_mc_in   = RECIP_65;
         end else begin
            s1_band_in = BAND_RED;
         end
      end

      s1_fac_in = FAC_ZERO;
      num_f     = '0;
      s1_mf_in  = '0;
      if (w_ext >= W380 && w_ext < W420) begin
         s1_fac_in = FAC_RAMP;
         num_f     = w_x7 - FAC_OFS_LO;
         s1_mf_in  = RECIP_400;
      end else if (w_ext >= W420 && w_ext < W701) begin
         s1_fac_in = FAC_ONE;
      end else if (w_ext >= W701 && w_ext < W781) begin
         s1_fac_in = FAC_RAMP;
         num_f     = FAC_OFS_HI - w_x7;
         s1_mf_in  = RECIP_800;
      end

      s1_xc_in = X_W'(num_c) << X_SHIFT;
      s1_xf_in = X_W'(num_f) << X_SHIFT;
   end

   // stage 2: ramp = numerator times reciprocal
   logic [MUL_W-1:0]  prod_c;
   logic [MUL_W-1:0]  prod_f;
   logic [RAMP_W-1:0] s2_qc_in;
   logic [RAMP_W-1:0] s2_qf_in;
   logic              s2_valid_ff;
   band_type          s2_band_ff;
   fac_type           s2_fac_ff;
   logic [RAMP_W-1:0] s2_qc_ff;
   logic [RAMP_W-1:0] s2_qf_ff;

   assign prod_c   = MUL_W'(s1_xc_ff) * MUL_W'(s1_mc_ff);
   assign prod_f   = MUL_W'(s1_xf_ff) * MUL_W'(s1_mf_ff);
   assign s2_qc_in = prod_c[RECIP_SHIFT +: RAMP_W];
   assign s2_qf_in = prod_f[RECIP_SHIFT +: RAMP_W];

   // stage 3: component times factor, gamma index
   logic [RAMP_W-1:0]           col_r;
   logic [RAMP_W-1:0]           col_g;
   logic [RAMP_W-1:0]           col_b;
   logic [RAMP_W-1:0]           fac;
   logic [PROD_W-1:0]           prod_r;
   logic [PROD_W-1:0]           prod_g;
   logic [PROD_W-1:0]           prod_b;
   logic                        s3_valid_ff;
   logic [GAMMA_INDEX_BITS-1:0] s3_idx_r_ff;
   logic [GAMMA_INDEX_BITS-1:0] s3_idx_g_ff;
   logic [GAMMA_INDEX_BITS-1:0] s3_idx_b_ff;

   always_comb begin
      col_r = '0;
      col_g = '0;
      col_b = '0;
      case (s2_band_ff)
         BAND_VB: begin
            col_r = s2_qc_ff;
            col_b = Q_ONE;
         end
         BAND_BC: begin
            col_g = s2_qc_ff;
            col_b = Q_ONE;
         end
         BAND_CG: begin
            col_g = Q_ONE;
            col_b = s2_qc_ff;
         end
         BAND_GY: begin
            col_r = s2_qc_ff;
            col_g = Q_ONE;
         end
         BAND_YR: begin
            col_r = Q_ONE;
            col_g = s2_qc_ff;
         end
         BAND_RED: begin
            col_r = Q_ONE;
         end
         default: begin
            col_r = '0;
         end
      endcase

      case (s2_fac_ff)
         FAC_ONE:  fac = Q_ONE;
         FAC_RAMP: fac = s2_qf_ff;
         default:  fac = '0;
      endcase
   end

   assign prod_r = PROD_W'(col_r) * PROD_W'(fac);
   assign prod_g = PROD_W'(col_g) * PROD_W'(fac);
   assign prod_b = PROD_W'(col_b) * PROD_W'(fac);

   // stage 4: gamma ROM, registered read
   logic rsp_valid_ff;

   w2rgb_gamma_rom #(
      .GAMMA_INDEX_BITS (GAMMA_INDEX_BITS)
   ) u_rom_red (
      .clock   (clock),
      .rd_idx  (s3_idx_r_ff),
      .rd_data (rsp_red)
   );

   w2rgb_gamma_rom #(
      .GAMMA_INDEX_BITS (GAMMA_INDEX_BITS)
   ) u_rom_green (
      .clock   (clock),
      .rd_idx  (s3_idx_g_ff),
      .rd_data (rsp_green)
   );

   w2rgb_gamma_rom #(
      .GAMMA_INDEX_BITS (GAMMA_INDEX_BITS)
   ) u_rom_blue (
      .clock   (clock),
      .rd_idx  (s3_idx_b_ff),
      .rd_data (rsp_blue)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_band_ff  <= s1_band_in;
      s1_fac_ff   <= s1_fac_in;
      s1_xc_ff    <= s1_xc_in;
      s1_xf_ff    <= s1_xf_in;
      s1_mc_ff    <= s1_mc_in;
      s1_mf_ff    <= s1_mf_in;
      s2_band_ff  <= s1_band_ff;
      s2_fac_ff   <= s1_fac_ff;
      s2_qc_ff    <= s2_qc_in;
      s2_qf_ff    <= s2_qf_in;
      s3_idx_r_ff <= shade_index(prod_r);
      s3_idx_g_ff <= shade_index(prod_g);
      s3_idx_b_ff <= shade_index(prod_b);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### design/w2rgb_checker.sv
`default_nettype none

`include "wavelength_to_rgb_defines.svh"

module w2rgb_assertions import w2rgb_pkg::*; #(
   parameter int WAVE_FRAC_BITS = WAVE_FRAC_BITS_DEF
) (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                start,
   input wire logic                busy,
   input wire logic [WAVE_W-1:0]   req_wavelength_q4,
   input wire logic                rsp_valid,
   input wire logic [COLOUR_W-1:0] rsp_red,
   input wire logic [COLOUR_W-1:0] rsp_green,
   input wire logic [COLOUR_W-1:0] rsp_blue
);

   localparam logic [31:0] WAVE_LO   = 32'd380 << WAVE_FRAC_BITS;
   localparam logic [31:0] WAVE_BLUE = 32'd440 << WAVE_FRAC_BITS;
   localparam logic [31:0] WAVE_CYAN = 32'd490 << WAVE_FRAC_BITS;

   logic        accept;
   logic [31:0] wave;
   logic        req_black;
   logic        req_blue;
   logic        rsp_black;
   logic        rsp_pure_blue;

   assign accept        = start && !busy;
   assign wave          = 32'(req_wavelength_q4);
   assign req_black     = accept && wave < WAVE_LO;
   assign req_blue      = accept && wave >= WAVE_BLUE && wave < WAVE_CYAN;
   assign rsp_black     = rsp_red == '0 && rsp_green == '0 && rsp_blue == '0;
   assign rsp_pure_blue = rsp_blue == '1 && rsp_red == '0;

   `W2RGB_ASSERT_ALWAYS(a_never_busy, clock, reset, !busy)

   `W2RGB_ASSERT_LATER(a_resp_follows, clock, reset, accept, PIPE_LATENCY, rsp_valid)

   `W2RGB_ASSERT_LATER(a_no_stray_resp, clock, reset, !accept, PIPE_LATENCY, !rsp_valid)

   `W2RGB_ASSERT_LATER(a_black_below, clock, reset, req_black, PIPE_LATENCY, rsp_black)

   `W2RGB_ASSERT_LATER(a_full_blue, clock, reset, req_blue, PIPE_LATENCY, rsp_pure_blue)

endmodule

bind wavelength_to_rgb w2rgb_assertions #(
   .WAVE_FRAC_BITS (WAVE_FRAC_BITS)
) u_w2rgb_assertions (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_wavelength_q4 (req_wavelength_q4),
   .rsp_valid         (rsp_valid),
   .rsp_red           (rsp_red),
   .rsp_green         (rsp_green),
   .rsp_blue          (rsp_blue)
);

`default_nettype wire

### sim/w2rgb_checker.sv
module w2rgb_checker import w2rgb_pkg::*; #(
   parameter int GAMMA_INDEX_BITS = GAMMA_INDEX_BITS_DEF,
   parameter int WAVE_FRAC_BITS   = WAVE_FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic [WAVE_W-1:0]   req_wavelength_q4,
   input  logic                rsp_valid,
   input  logic [COLOUR_W-1:0] rsp_red,
   input  logic [COLOUR_W-1:0] rsp_green,
   input  logic [COLOUR_W-1:0] rsp_blue,
   output int                  failures,
   output int                  outstanding,
   output int                  checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [COLOUR_W-1:0] red;
      logic [COLOUR_W-1:0] green;
      logic [COLOUR_W-1:0] blue;
   } rgb_type;

   localparam int          IDX_MAX  = (1 << GAMMA_INDEX_BITS) - 1;
   localparam logic [63:0] NM       = 64'd1 << WAVE_FRAC_BITS;
   localparam logic [63:0] UNITY    = 64'd1 << Q_FRAC;

   logic [COLOUR_W-1:0] gamma_lut [0:IDX_MAX];
   rgb_type             colour_due [$];
   int                  fail_count = 0;
   int                  check_count = 0;

   // largest v with (v/255)^5 <= (i/M)^4, exact in wide integers
   initial begin : build_gamma
      logic [127:0] m4, k5, i4, c5;
      logic [7:0]   v, c;
      m4 = 128'(IDX_MAX);
      m4 = m4 * m4;
      m4 = m4 * m4;
      k5 = 128'd255;
      k5 = k5 * k5 * k5 * k5 * k5;
      for (int i = 0; i <= IDX_MAX; i++) begin
         i4 = 128'(i);
         i4 = i4 * i4;
         i4 = i4 * i4;
         v  = 8'd0;
         for (int b = 7; b >= 0; b--) begin
            c  = v | (8'd1 << b);
            c5 = 128'(c);
            c5 = c5 * c5 * c5 * c5 * c5;
            if (c5 * m4 <= i4 * k5)
               v = c;
         end
         gamma_lut[i] = v;
      end
   end

   function automatic logic [63:0] q16_ratio(input logic [63:0] num, input logic [63:0] den);
      return (num << Q_FRAC) / den;
   endfunction

   function automatic logic [COLOUR_W-1:0] shade(input logic [63:0] c, input logic [63:0] f);
      logic [63:0] p;
      p = (c * f) >> Q_FRAC;
      if (p > 64'd65535)
         p = 64'd65535;
      return gamma_lut[p >> (Q_FRAC - GAMMA_INDEX_BITS)];
   endfunction

   function automatic rgb_type wavelength_colour(input logic [WAVE_W-1:0] wq);
      logic [63:0] w, r, g, b, f;
      rgb_type     o;
      w = 64'(wq);
      r = '0;
      g = '0;
      b = '0;
      f = '0;
      if (w >= 380 * NM && w < 440 * NM) begin
         r = q16_ratio(440 * NM - w, 60 * NM);
         b = UNITY;
      end else if (w >= 440 * NM && w < 490 * NM) begin
         g = q16_ratio(w - 440 * NM, 50 * NM);
         b = UNITY;
      end else if (w >= 490 * NM && w < 510 * NM) begin
         g = UNITY;
         b = q16_ratio(510 * NM - w, 20 * NM);
      end else if (w >= 510 * NM && w < 580 * NM) begin
         r = q16_ratio(w - 510 * NM, 70 * NM);
         g = UNITY;
      end else if (w >= 580 * NM && w < 645 * NM) begin
         r = UNITY;
         g = q16_ratio(645 * NM - w, 65 * NM);
      end else if (w >= 645 * NM && w < 781 * NM) begin
         r = UNITY;
      end
      // edge intensity: rises over 380..420, falls from 701 on
      if (w >= 380 * NM && w < 420 * NM)
         f = q16_ratio(7 * w - 2540 * NM, 400 * NM);
      else if (w >= 420 * NM && w < 701 * NM)
         f = UNITY;
      else if (w >= 701 * NM && w < 781 * NM)
         f = q16_ratio(5700 * NM - 7 * w, 800 * NM);
      o.red   = shade(r, f);
      o.green = shade(g, f);
      o.blue  = shade(b, f);
      return o;
   endfunction

   always @(posedge clock) begin
      rgb_type due;
      if (reset) begin
         colour_due.delete();
      end else begin
         if (rsp_valid) begin
            if (colour_due.size() == 0) begin
               $error("response with no request pending: red %0d green %0d blue %0d",
                      rsp_red, rsp_green, rsp_blue);
               fail_count++;
            end else begin
               due = colour_due.pop_front();
               check_count++;
               if (rsp_red !== due.red) begin
                  $error("red: expected %0d actual %0d", due.red, rsp_red);
                  fail_count++;
               end
               if (rsp_green !== due.green) begin
                  $error("green: expected %0d actual %0d", due.green, rsp_green);
                  fail_count++;
               end
               if (rsp_blue !== due.blue) begin
                  $error("blue: expected %0d actual %0d", due.blue, rsp_blue);
                  fail_count++;
               end
            end
         end
         if (start && !busy)
            colour_due.push_back(wavelength_colour(req_wavelength_q4));
      end
      failures    <= fail_count;
      checked     <= check_count;
      outstanding <= colour_due.size();
   end

endmodule

### sim/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import w2rgb_pkg::*;

   localparam int HALF_PERIOD    = 4;
   localparam int RESET_CYCLES   = 7;
   localparam int RANDOM_ITEMS   = 600;
   localparam int QUIET_TAIL     = 100;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int F              = WAVE_FRAC_BITS_DEF;
   localparam int WAVE_MAX       = (1 << WAVE_W) - 1;

   localparam int BAND_EDGES [10] = '{380, 420, 440, 490, 510, 580, 645, 701, 780, 781};
   localparam int DIRECTED [25] = '{
      0, WAVE_MAX,
      (380 << F) - 1, 380 << F, (420 << F) - 1, 420 << F,
      (440 << F) - 1, 440 << F, (490 << F) - 1, 490 << F,
      (510 << F) - 1, 510 << F, (580 << F) - 1, 580 << F,
      (645 << F) - 1, 645 << F, (701 << F) - 1, 701 << F,
      780 << F, (781 << F) - 1, 781 << F,
      (400 << F) + 7, (550 << F) + 9, 14'h2aaa, 14'h1555
   };

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic [WAVE_W-1:0]   req_wavelength_q4 = '0;
   logic                busy;
   logic                rsp_valid;
   logic [COLOUR_W-1:0] rsp_red;
   logic [COLOUR_W-1:0] rsp_green;
   logic [COLOUR_W-1:0] rsp_blue;

   int failures;
   int outstanding;
   int checked;
   int sent = 0;
   int visible_sent = 0;
   int quiet_cycles = 0;

   always #(HALF_PERIOD) clock = ~clock;

   wavelength_to_rgb dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_wavelength_q4 (req_wavelength_q4),
      .rsp_valid         (rsp_valid),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue)
   );

   w2rgb_checker colour_check (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_wavelength_q4 (req_wavelength_q4),
      .rsp_valid         (rsp_valid),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue),
      .failures          (failures),
      .outstanding       (outstanding),
      .checked           (checked)
   );

   task automatic send_request(input int w);
      req_wavelength_q4 <= WAVE_W'(w);
      start             <= 1'b1;
      sent++;
      if ((w >> F) >= 380 && (w >> F) < 781)
         visible_sent++;
      @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   task automatic idle_burst(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   initial begin
      int w;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED[k])
         send_request(DIRECTED[k]);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 7) == 0)
            idle_burst($urandom_range(1, 11));
         case ($urandom_range(0, 9))
            0: w = $urandom_range(0, WAVE_MAX);
            1, 2: begin
               // close to a band or ramp boundary
               w = (BAND_EDGES[$urandom_range(0, 9)] << F) + $urandom_range(0, 40) - 20;
               if (w < 0) w = 0;
               if (w > WAVE_MAX) w = WAVE_MAX;
            end
            default: w = $urandom_range(380 << F, (781 << F) - 1);
         endcase
         send_request(w);
      end
      start <= 1'b0;

      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (PIPE_LATENCY + 4) @(posedge clock);

      $display("%0d requests sent (%0d directed, %0d inside 380-781 nm), %0d responses checked",
               sent, $size(DIRECTED), visible_sent, checked);
      if (failures == 0 && outstanding == 0)
         $display("PASS wavelength_to_rgb");
      else
         $display("FAIL wavelength_to_rgb");
      $finish;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("stalled for %0d cycles with %0d responses pending", quiet_cycles, outstanding);
         $display("FAIL wavelength_to_rgb");
         $finish;
      end
   end

endmodule
